// ===== rtl/sstp_pkg.sv =====
// shared types, constants and register codes for the solenoid stroke timing block
`timescale 1ns / 1ps

package sstp_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_RISE_THR   = 3'd0;
  localparam logic [2:0] REG_FALL_THR   = 3'd1;
  localparam logic [2:0] REG_OFFSET     = 3'd2;
  localparam logic [2:0] REG_TARGET     = 3'd3;
  localparam logic [2:0] REG_BASE_DUTY  = 3'd4;
  localparam logic [2:0] REG_DUTY_FLOOR = 3'd5;
  localparam logic [2:0] REG_DUTY_CEIL  = 3'd6;

  localparam logic [11:0] RST_RISE_THR   = 12'd1200;
  localparam logic [11:0] RST_FALL_THR   = 12'd2400;
  localparam logic [15:0] RST_OFFSET     = 16'd2370;
  localparam logic [7:0]  RST_TARGET     = 8'd50;
  localparam logic [7:0]  RST_BASE_DUTY  = 8'd80;
  localparam logic [7:0]  RST_DUTY_FLOOR = 8'd10;
  localparam logic [7:0]  RST_DUTY_CEIL  = 8'd235;

  localparam logic CMD_ARM    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // position = excess / 17, clamped to 100
  localparam int unsigned POS_DIVISOR = 17;
  localparam logic [6:0]  POS_MAX     = 7'd100;
  localparam logic [15:0] POS_LIMIT   = 16'(100 * POS_DIVISOR);
  localparam int unsigned POS_SHIFT   = 20;
  localparam logic [15:0] POS_RECIP   = 16'((2 ** POS_SHIFT) / POS_DIVISOR + 1);

  typedef enum logic [1:0] {
    PH_RISE = 2'd0,
    PH_FALL = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic        command;
    logic [11:0] sample_mv;
    logic [15:0] timestamp_us;
  } item_t;

  typedef struct packed {
    logic [15:0] interval_us;
    logic [6:0]  position;
    logic [7:0]  duty;
    logic        interval_valid;
  } result_t;

  typedef struct packed {
    logic [11:0] rise_threshold_mv;
    logic [11:0] fall_threshold_mv;
    logic [15:0] interval_offset_us;
    logic [7:0]  target_position;
    logic [7:0]  base_duty;
    logic [7:0]  duty_floor;
    logic [7:0]  duty_ceiling;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] rise_time;
    logic [7:0]  duty_value;
  } state_t;

  typedef struct packed {
    logic    fire;
    state_t  state_next;
    result_t res;
  } calc_t;

endpackage

// ===== rtl/sstp_if.sv =====
// request channels for samples in and results out
`timescale 1ns / 1ps

interface sstp_item_if
  import sstp_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sstp_result_if
  import sstp_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/sstp_cfg_regs.sv =====
// apb configuration register file
`timescale 1ns / 1ps

module sstp_cfg_regs
  import sstp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_threshold_mv  <= RST_RISE_THR;
      cfg.fall_threshold_mv  <= RST_FALL_THR;
      cfg.interval_offset_us <= RST_OFFSET;
      cfg.target_position    <= RST_TARGET;
      cfg.base_duty          <= RST_BASE_DUTY;
      cfg.duty_floor         <= RST_DUTY_FLOOR;
      cfg.duty_ceiling       <= RST_DUTY_CEIL;
    end else if (wr_en) begin
      unique case (index)
        REG_RISE_THR:   cfg.rise_threshold_mv  <= pwdata[11:0];
        REG_FALL_THR:   cfg.fall_threshold_mv  <= pwdata[11:0];
        REG_OFFSET:     cfg.interval_offset_us <= pwdata[15:0];
        REG_TARGET:     cfg.target_position    <= pwdata[7:0];
        REG_BASE_DUTY:  cfg.base_duty          <= pwdata[7:0];
        REG_DUTY_FLOOR: cfg.duty_floor         <= pwdata[7:0];
        REG_DUTY_CEIL:  cfg.duty_ceiling       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_RISE_THR:   prdata = PDATA_W'(cfg.rise_threshold_mv);
      REG_FALL_THR:   prdata = PDATA_W'(cfg.fall_threshold_mv);
      REG_OFFSET:     prdata = PDATA_W'(cfg.interval_offset_us);
      REG_TARGET:     prdata = PDATA_W'(cfg.target_position);
      REG_BASE_DUTY:  prdata = PDATA_W'(cfg.base_duty);
      REG_DUTY_FLOOR: prdata = PDATA_W'(cfg.duty_floor);
      REG_DUTY_CEIL:  prdata = PDATA_W'(cfg.duty_ceiling);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sstp_calc.sv =====
// per-sample phase tracking, interval, position and duty step
`timescale 1ns / 1ps

module sstp_calc
  import sstp_pkg::*;
(
  input  item_t  item,
  input  state_t state,
  input  cfg_t   cfg,
  output calc_t  calc
);

  logic [15:0]       interval;
  logic              ivl_valid;
  logic [15:0]       excess;
  logic [26:0]       prod;
  logic [6:0]        pos_raw;
  logic [6:0]        pos;
  logic signed [9:0] d_cur;
  logic signed [9:0] d_step;
  logic signed [9:0] d_floor;
  logic signed [9:0] d_ceil;
  logic [7:0]        duty_adj;

  assign interval  = item.timestamp_us - state.rise_time;
  assign ivl_valid = item.timestamp_us > state.rise_time;
  assign excess    = interval - cfg.interval_offset_us;
  assign prod      = 27'(excess[10:0]) * 27'(POS_RECIP);
  assign pos_raw   = prod[26:POS_SHIFT];

  always_comb begin
    if (!ivl_valid || interval <= cfg.interval_offset_us) begin
      pos = '0;
    end else if (excess >= POS_LIMIT) begin
      pos = POS_MAX;
    end else begin
      pos = pos_raw;
    end
  end

  // one step toward target, floor test wins over ceiling
  assign d_cur   = signed'({2'b00, state.duty_value});
  assign d_floor = signed'({2'b00, cfg.duty_floor});
  assign d_ceil  = signed'({2'b00, cfg.duty_ceiling});

  always_comb begin
    if ({1'b0, pos} > cfg.target_position) begin
      d_step = d_cur - 10'sd1;
    end else if ({1'b0, pos} < cfg.target_position) begin
      d_step = d_cur + 10'sd1;
    end else begin
      d_step = d_cur;
    end
    if (d_step < d_floor) begin
      duty_adj = cfg.duty_floor;
    end else if (d_step > d_ceil) begin
      duty_adj = cfg.duty_ceiling;
    end else begin
      duty_adj = d_step[7:0];
    end
  end

  always_comb begin
    calc.fire       = 1'b0;
    calc.state_next = state;
    if (item.command == CMD_ARM) begin
      calc.state_next.phase      = PH_RISE;
      calc.state_next.duty_value = cfg.base_duty;
    end else begin
      unique case (state.phase)
        PH_RISE: begin
          if (item.sample_mv > cfg.rise_threshold_mv) begin
            calc.state_next.phase     = PH_FALL;
            calc.state_next.rise_time = item.timestamp_us;
          end
        end
        PH_FALL: begin
          if (item.sample_mv < cfg.fall_threshold_mv) begin
            calc.fire                  = 1'b1;
            calc.state_next.phase      = PH_DONE;
            if (ivl_valid) begin
              calc.state_next.duty_value = duty_adj;
            end
          end
        end
        default: ;
      endcase
    end
    calc.res.interval_us    = interval;
    calc.res.position       = pos;
    calc.res.duty           = calc.state_next.duty_value;
    calc.res.interval_valid = ivl_valid;
  end

endmodule

// ===== rtl/solenoid_stroke_timing_position_top.sv =====
// top level of the solenoid stroke timing and position estimator
`timescale 1ns / 1ps

// Takes one request per cycle: an arm command or a timestamped converter sample.
// A sample is registered into the input stage and evaluated against the phase state;
// a falling-crossing result is then registered into the output register and offered.
// The rate is one request per clock, set by the single evaluation stage that owns
// the phase, rise time and duty state; the input stage holds only while a new
// result meets a result not yet taken. Configuration registers sit on the apb port
// at byte address 4 * index.

module solenoid_stroke_timing_position_top
  import sstp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  sstp_item_if.sink           item,
  sstp_result_if.source       result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t    cfg;
  state_t  state;
  calc_t   calc;
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_adv;
  logic    out_valid;
  result_t out_data;

  sstp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sstp_calc u_calc (
    .item  (s1_item),
    .state (state),
    .cfg   (cfg),
    .calc  (calc)
  );

  assign s1_adv       = !calc.fire || !out_valid || result.ready;
  assign item.ready   = !s1_valid || s1_adv;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready) begin
      s1_item <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_RISE;
      state.rise_time  <= '0;
      state.duty_value <= RST_BASE_DUTY;
    end else if (s1_valid && s1_adv) begin
      state <= calc.state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv && calc.fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv && calc.fire) begin
      out_data <= calc.res;
    end
  end

  a_rise_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> state.phase == PH_DONE)
    else $error("result without done phase");

  a_invalid_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.interval_valid |-> out_data.position == '0)
    else $error("invalid interval with nonzero position");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.position <= POS_MAX)
    else $error("position above limit");

  a_taken_held: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> s1_valid)
    else $error("accepted request lost");

endmodule
